// File: sv/mtb_pkg.sv
// Shared types and constants for the markup tag balance checker.
// Holds the transaction payloads, marker bytes and error codes; no dependencies.
package mtb_pkg;

  localparam logic [7:0] CH_OPEN  = 8'h3C;
  localparam logic [7:0] CH_CLOSE = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_MISMATCH = 2'd1,
    ERR_UNCLOSED = 2'd2,
    ERR_OVERFLOW = 2'd3
  } mtb_err_t;

  typedef struct packed {
    logic       data_byte_unused_guard;
  } mtb_reserved_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } mtb_in_t;

  typedef struct packed {
    logic       balanced;
    logic [1:0] status;
  } mtb_out_t;

  typedef struct packed {
    logic     tag_open;
    logic     closing;
    logic     cfail;
    mtb_err_t err;
  } mtb_flags_t;

endpackage

// File: sv/mtb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the tag text store and the entry length store; no dependencies.
module mtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/mtb_step.sv
// Next-state logic for one document byte: tag tracking, compare, push and pop.
// Depends on mtb_pkg for the flag struct, marker bytes and error codes.
module mtb_step #(
  parameter int STACK_DEPTH = 16,
  parameter int TAG_LENGTH  = 32
) (
  input  logic [7:0]                         byte_i,
  input  mtb_pkg::mtb_flags_t                flags_i,
  input  logic [$clog2(STACK_DEPTH+1)-1:0]   count_i,
  input  logic [$clog2(TAG_LENGTH+2)-1:0]    pos_i,
  input  logic [$clog2(TAG_LENGTH+1)-1:0]    top_len_i,
  input  logic [7:0]                         top_byte_i,
  output mtb_pkg::mtb_flags_t                flags_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0]   count_o,
  output logic [$clog2(TAG_LENGTH+2)-1:0]    pos_o,
  output logic                               txt_we_o,
  output logic                               len_we_o,
  output mtb_pkg::mtb_err_t                  status_o
);
  import mtb_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH+1);
  localparam int POS_W = $clog2(TAG_LENGTH+2);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);
  localparam logic [POS_W-1:0] TAG_MAX = POS_W'(TAG_LENGTH);

  logic [POS_W-1:0] top_len_ext;

  assign top_len_ext = POS_W'(top_len_i);

  always_comb begin
    flags_o  = flags_i;
    count_o  = count_i;
    pos_o    = pos_i;
    txt_we_o = 1'b0;
    len_we_o = 1'b0;
    if (!flags_i.tag_open) begin
      if (byte_i == CH_OPEN) begin
        flags_o.tag_open = 1'b1;
        flags_o.closing  = 1'b0;
        flags_o.cfail    = 1'b0;
        pos_o            = '0;
      end
    end else if (byte_i == CH_CLOSE) begin
      if (flags_i.err == ERR_NONE) begin
        if (flags_i.closing) begin
          if (count_i == '0 || flags_i.cfail || pos_i != top_len_ext) begin
            flags_o.err = ERR_MISMATCH;
          end else begin
            count_o = count_i - 1'b1;
          end
        end else if (pos_i > TAG_MAX || count_i >= DEPTH_C) begin
          flags_o.err = ERR_OVERFLOW;
        end else begin
          len_we_o = 1'b1;
          count_o  = count_i + 1'b1;
        end
      end
      flags_o.tag_open = 1'b0;
      flags_o.closing  = 1'b0;
      flags_o.cfail    = 1'b0;
      pos_o            = '0;
    end else begin
      if (pos_i == '0 && !flags_i.closing && byte_i == CH_SLASH) begin
        flags_o.closing = 1'b1;
      end else begin
        if (flags_i.closing) begin
          if (count_i == '0 || pos_i >= top_len_ext || pos_i >= TAG_MAX ||
              top_byte_i != byte_i) begin
            flags_o.cfail = 1'b1;
          end
        end else if (count_i < DEPTH_C && pos_i < TAG_MAX) begin
          txt_we_o = 1'b1;
        end
        if (pos_i <= TAG_MAX) begin
          pos_o = pos_i + 1'b1;
        end
      end
    end

    if (flags_o.err != ERR_NONE) begin
      status_o = flags_o.err;
    end else if (count_o != '0) begin
      status_o = ERR_UNCLOSED;
    end else begin
      status_o = ERR_NONE;
    end
  end

endmodule

// File: sv/markup_tag_balance_checker_core.sv
// Markup tag balance checker: input register, byte step logic, result register.
// Result: registered from the last byte in the input register, once no older result stalls.
// Throughput: one byte per cycle unless stalled, set by one text store read feeding one compare per cycle.
// The text store read is prefetched from the next state so its data meets the next byte.
// Reset: rst_n synchronous, active low; clears control state only, stores are not cleared.
// Depends on mtb_pkg, mtb_step and mtb_ram.
module markup_tag_balance_checker_core #(
  parameter int STACK_DEPTH = 16,
  parameter int TAG_LENGTH  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mtb_pkg::mtb_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mtb_pkg::mtb_out_t out_data
);
  import mtb_pkg::*;

  localparam int CNT_W  = $clog2(STACK_DEPTH+1);
  localparam int POS_W  = $clog2(TAG_LENGTH+2);
  localparam int LEN_W  = $clog2(TAG_LENGTH+1);
  localparam int ROW_W  = $clog2(STACK_DEPTH);
  localparam int COL_W  = $clog2(TAG_LENGTH);
  localparam int TXT_DEPTH = STACK_DEPTH * TAG_LENGTH;
  localparam int ADDR_W = $clog2(TXT_DEPTH);

  logic             s1_valid_r, s1_valid_nxt;
  mtb_in_t          s1_data_r;
  logic             s1_go, in_take;

  mtb_flags_t       flags_r, flags_nxt, flags_step;
  logic [CNT_W-1:0] count_r, count_nxt, count_step;
  logic [POS_W-1:0] pos_r, pos_nxt, pos_step;
  logic             txt_we, len_we, txt_we_go, len_we_go;
  mtb_err_t         status_step;

  logic             out_valid_r, out_valid_nxt;
  mtb_out_t         out_data_r;

  logic [ROW_W-1:0] row_rd, row_wr;
  logic [COL_W-1:0] col_rd, col_wr;
  logic [ADDR_W-1:0] txt_raddr, txt_waddr;
  logic [7:0]       txt_rdata;
  logic [LEN_W-1:0] len_rdata, len_wdata, top_len;
  logic             len_fwd_r, len_fwd_nxt;
  logic [LEN_W-1:0] len_fwd_data_r;

  assign s1_go    = s1_valid_r && !(s1_data_r.last_byte && out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;
  assign s1_valid_nxt = in_take || (s1_valid_r && !s1_go);

  assign top_len = len_fwd_r ? len_fwd_data_r : len_rdata;

  mtb_step #(
    .STACK_DEPTH(STACK_DEPTH),
    .TAG_LENGTH (TAG_LENGTH)
  ) u_step (
    .byte_i    (s1_data_r.data_byte),
    .flags_i   (flags_r),
    .count_i   (count_r),
    .pos_i     (pos_r),
    .top_len_i (top_len),
    .top_byte_i(txt_rdata),
    .flags_o   (flags_step),
    .count_o   (count_step),
    .pos_o     (pos_step),
    .txt_we_o  (txt_we),
    .len_we_o  (len_we),
    .status_o  (status_step)
  );

  always_comb begin
    flags_nxt = flags_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    if (s1_go) begin
      if (s1_data_r.last_byte) begin
        flags_nxt = '{tag_open: 1'b0, closing: 1'b0, cfail: 1'b0, err: ERR_NONE};
        count_nxt = '0;
        pos_nxt   = '0;
      end else begin
        flags_nxt = flags_step;
        count_nxt = count_step;
        pos_nxt   = pos_step;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (s1_go && s1_data_r.last_byte) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign txt_we_go = s1_go && txt_we;
  assign len_we_go = s1_go && len_we;

  assign row_rd = (count_nxt == '0) ? '0 : ROW_W'(count_nxt - 1'b1);
  assign col_rd = (pos_nxt >= POS_W'(TAG_LENGTH)) ? COL_W'(TAG_LENGTH - 1) : COL_W'(pos_nxt);
  assign row_wr = ROW_W'(count_r);
  assign col_wr = COL_W'(pos_r);
  assign txt_raddr = ADDR_W'(ADDR_W'(row_rd) * ADDR_W'(TAG_LENGTH) + ADDR_W'(col_rd));
  assign txt_waddr = ADDR_W'(ADDR_W'(row_wr) * ADDR_W'(TAG_LENGTH) + ADDR_W'(col_wr));
  assign len_wdata = LEN_W'(pos_r);
  assign len_fwd_nxt = len_we_go && (row_wr == row_rd);

  mtb_ram #(
    .WIDTH(8),
    .DEPTH(TXT_DEPTH)
  ) u_txt_ram (
    .clk  (clk),
    .we   (txt_we_go),
    .waddr(txt_waddr),
    .wdata(s1_data_r.data_byte),
    .raddr(txt_raddr),
    .rdata(txt_rdata)
  );

  mtb_ram #(
    .WIDTH(LEN_W),
    .DEPTH(STACK_DEPTH)
  ) u_len_ram (
    .clk  (clk),
    .we   (len_we_go),
    .waddr(row_wr),
    .wdata(len_wdata),
    .raddr(row_rd),
    .rdata(len_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '{tag_open: 1'b0, closing: 1'b0, cfail: 1'b0, err: ERR_NONE};
      count_r     <= '0;
      pos_r       <= '0;
      len_fwd_r   <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      flags_r     <= flags_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      len_fwd_r   <= len_fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
    if (s1_go && s1_data_r.last_byte) begin
      out_data_r.balanced <= (status_step == ERR_NONE);
      out_data_r.status   <= status_step;
    end
    len_fwd_data_r <= len_wdata;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
